>>> design/svsl_pkg.sv
// ----------------------------------------------------------------------------
// svsl_pkg: shared types and constants of the servo setpoint unit
// Channel count, item codes, register indexes, arithmetic widths and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package svsl_pkg;

  localparam int NUM_CH   = 4;                          // servo channels
  localparam int MAX_RES  = 4;                          // results per tick at most
  localparam int NUM_RES  = (NUM_CH < MAX_RES) ? NUM_CH : MAX_RES;
  localparam int CH_W     = 2;                          // channel field width

  localparam int NUM_W    = 24;                         // product / dividend width
  localparam int DIV_W    = 16;                         // divisor width
  localparam int CNT_W    = $clog2(NUM_W);              // divider step counter

  // position and pulse constants
  localparam logic [7:0]  POS_RESET = 8'd128;
  localparam logic [7:0]  POS_MAX   = 8'd255;
  localparam logic [7:0]  TGT_MIN   = 8'd20;
  localparam logic [7:0]  TGT_MAX   = 8'd235;
  localparam logic [14:0] PW_MUL    = 15'd75;
  localparam int          PW_SHIFT  = 4;                // divide by 16
  localparam logic [11:0] PW_OFS    = 12'd900;

  // register reset values
  localparam logic [7:0]         MAX_STEP_RST = 8'd6;
  localparam logic [7:0]         CENTER_RST   = 8'd128;
  localparam logic [14:0]        LEFT_RST     = 15'd5200;
  localparam logic signed [15:0] RIGHT_RST    = -16'sd5000;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_RAW    = 2'd1,
    CMD_ANGLE  = 2'd2,
    CMD_ENABLE = 2'd3
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_STEP = 2'd0,
    REG_CENTER   = 2'd1,
    REG_LEFT     = 2'd2,
    REG_RIGHT    = 2'd3
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic            cap;        // capture the accepted item
    logic            set_raw;    // write raw target
    logic            set_en;     // write enable flag
    logic            slew;       // step every channel toward its target
    logic            ang_prep;   // angle-to-target product and divisor
    logic            t2a_prep;   // target-to-angle product and divisor
    logic            div_step;   // one restoring division step
    logic            ang_wr;     // write the converted target
    logic            out_load;   // load the result register
    logic            last;       // final result of the tick
    logic [CH_W-1:0] idx;        // channel being reported
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_code_t item_cmd;         // code of the captured item
    logic      out_busy;         // result register full and not taken
  } dp_sts_t;

endpackage

>>> design/servo_slew_limited_setpoints_unit.sv
// ----------------------------------------------------------------------------
// servo_slew_limited_setpoints_unit: four-channel slew-limited servo setpoints
// Stores a target and an actual position per channel, converts angle
// requests to targets and, on each tick, steps positions and reports them.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake          | moves
//   ---------+-----------+--------------------+-------------------------------
//   in_      | in        | in_valid/in_ready  | one command item
//   out_     | out       | out_valid/out_ready| one channel report
//   cfg_     | in        | cfg_valid/cfg_ready| one register write
//
// Raw-target and enable items are written in the decode state; an angle
// item runs through the 24-step serial divider. On a tick, each channel's
// target-to-angle conversion runs through the same divider.
// Items are taken one at a time; a stalled result holds the sequencer only
// when the next report is ready, and a new item may enter while the last
// report of a tick waits. Synchronous active-low reset restores all positions
// and targets to 128, enables to 1 and the registers to their defaults.
// Configuration writes are taken on every cycle.
// ----------------------------------------------------------------------------
module servo_slew_limited_setpoints_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // command items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_command,
  input  logic [svsl_pkg::CH_W-1:0]         in_channel,
  input  logic [7:0]                        in_raw_target,
  input  logic signed [15:0]                in_angle_in,
  input  logic                              in_enable_flag,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [svsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svsl_pkg::CFG_DATA_W-1:0]   cfg_data,
  // channel reports
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [svsl_pkg::CH_W-1:0]         out_channel,
  output logic [11:0]                       out_pulse_width,
  output logic [7:0]                        out_position,
  output logic [7:0]                        out_goal,
  output logic signed [15:0]                out_goal_angle,
  output logic                              out_active,
  output logic                              out_last
);
  import svsl_pkg::*;

  ctrl_cmd_t cmd;   // sequencer commands
  dp_sts_t   sts;   // datapath status

  // sequencer: decode, divider step count, channel walk
  svsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // state, arithmetic and result register
  svsl_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_command      (in_command),
    .in_channel      (in_channel),
    .in_raw_target   (in_raw_target),
    .in_angle_in     (in_angle_in),
    .in_enable_flag  (in_enable_flag),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_pulse_width (out_pulse_width),
    .out_position    (out_position),
    .out_goal        (out_goal),
    .out_goal_angle  (out_goal_angle),
    .out_active      (out_active),
    .out_last        (out_last)
  );

endmodule

>>> design/svsl_ctrl.sv
// ----------------------------------------------------------------------------
// svsl_ctrl: sequencer of the servo setpoint unit
// Decodes each item, runs the shared divider for its step count and walks
// the channels of a tick one result at a time.
// ----------------------------------------------------------------------------
module svsl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  svsl_pkg::dp_sts_t    sts,
  output svsl_pkg::ctrl_cmd_t  cmd
);
  import svsl_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_ANG_MUL = 9'b000000100,
    S_ANG_DIV = 9'b000001000,
    S_ANG_WR  = 9'b000010000,
    S_SLEW    = 9'b000100000,
    S_T2A_MUL = 9'b001000000,
    S_T2A_DIV = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CH_W-1:0]  idx_r, idx_nxt;
  logic             div_done;
  logic             last_ch;

  assign div_done = (cnt_r == CNT_W'(NUM_W - 1));
  assign last_ch  = (idx_r == CH_W'(NUM_RES - 1));
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.item_cmd)
          CMD_RAW: begin
            cmd.set_raw = 1'b1;
            state_nxt   = S_IDLE;
          end
          CMD_ENABLE: begin
            cmd.set_en = 1'b1;
            state_nxt  = S_IDLE;
          end
          CMD_ANGLE: state_nxt = S_ANG_MUL;
          default:   state_nxt = S_SLEW;
        endcase
      end
      S_ANG_MUL: begin
        cmd.ang_prep = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_ANG_DIV;
      end
      S_ANG_DIV: begin
        cmd.div_step = 1'b1;
        if (div_done) begin
          cnt_nxt   = '0;
          state_nxt = S_ANG_WR;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_ANG_WR: begin
        cmd.ang_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SLEW: begin
        cmd.slew  = 1'b1;
        idx_nxt   = '0;
        state_nxt = S_T2A_MUL;
      end
      S_T2A_MUL: begin
        cmd.t2a_prep = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_T2A_DIV;
      end
      S_T2A_DIV: begin
        cmd.div_step = 1'b1;
        if (div_done) begin
          cnt_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.last     = last_ch;
          if (last_ch) begin
            idx_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CH_W'(1);
            state_nxt = S_T2A_MUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

>>> design/svsl_datapath.sv
// ----------------------------------------------------------------------------
// svsl_datapath: channel state, registers, multiplier, divider and result
// Holds positions, targets and flags, the shared 16x8 multiplier and the
// one-bit-per-cycle restoring divider, and the output register.
// ----------------------------------------------------------------------------
module svsl_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  svsl_pkg::ctrl_cmd_t               cmd,
  output svsl_pkg::dp_sts_t                 sts,
  input  logic [1:0]                        in_command,
  input  logic [svsl_pkg::CH_W-1:0]         in_channel,
  input  logic [7:0]                        in_raw_target,
  input  logic signed [15:0]                in_angle_in,
  input  logic                              in_enable_flag,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [svsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svsl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [svsl_pkg::CH_W-1:0]         out_channel,
  output logic [11:0]                       out_pulse_width,
  output logic [7:0]                        out_position,
  output logic [7:0]                        out_goal,
  output logic signed [15:0]                out_goal_angle,
  output logic                              out_active,
  output logic                              out_last
);
  import svsl_pkg::*;

  typedef enum logic [1:0] {
    MODE_POS = 2'd0,   // angle >= 0 to target
    MODE_NEG = 2'd1,   // angle < 0 to target
    MODE_LO  = 2'd2,   // target at or below centre to angle
    MODE_HI  = 2'd3    // target above centre to angle
  } mode_t;

  // configuration
  logic [7:0]         ms_r;
  logic [7:0]         cp_r;
  logic [14:0]        ll_r;
  logic signed [15:0] rl_r;

  // channel state
  logic [7:0] act_r [NUM_CH];
  logic [7:0] tgt_r [NUM_CH];
  logic       en_r  [NUM_CH];
  logic [7:0] act_nxt [NUM_CH];

  // captured item
  cmd_code_t          cmd_r;
  logic [CH_W-1:0]    ch_r;
  logic [7:0]         raw_r;
  logic signed [15:0] ang_r;
  logic               flag_r;
  logic               ch_ok;

  // arithmetic
  mode_t              mode_r;
  logic               zdiv_r;
  logic [DIV_W-1:0]   div_r;
  logic [DIV_W-1:0]   rem_r;
  logic [NUM_W-1:0]   quo_r;
  logic [15:0]        mul_a;
  logic [7:0]         mul_b;
  logic [NUM_W-1:0]   prod;
  logic [DIV_W-1:0]   div_sel;
  logic               zdiv_sel;
  mode_t              mode_sel;
  logic [DIV_W:0]     shl;
  logic               ge;

  // helpers
  logic [7:0]         c_comp;      // 255 - centre
  logic [15:0]        rl_abs;
  logic [14:0]        a_pos;
  logic signed [15:0] a_neg;
  logic [15:0]        a_abs;
  logic [7:0]         t_sel;
  logic [NUM_W-1:0]   qv;
  logic [7:0]         t_raw;
  logic [7:0]         t_new;
  logic [15:0]        g_ang;
  logic [14:0]        pw_prod;
  logic [11:0]        pw;

  // output register
  logic               out_valid_r;
  logic [CH_W-1:0]    out_ch_r;
  logic [11:0]        out_pw_r;
  logic [7:0]         out_pos_r;
  logic [7:0]         out_goal_r;
  logic [15:0]        out_ang_r;
  logic               out_act_r;
  logic               out_last_r;

  assign cfg_ready    = 1'b1;
  assign sts.item_cmd = cmd_r;
  assign sts.out_busy = out_valid_r && !out_ready;
  assign ch_ok        = ({1'b0, ch_r} < (CH_W + 1)'(NUM_CH));

  assign c_comp = POS_MAX - cp_r;
  assign rl_abs = rl_r[15] ? (~rl_r + 16'd1) : rl_r;
  assign a_pos  = (ang_r[14:0] > ll_r) ? ll_r : ang_r[14:0];
  assign a_neg  = (ang_r < rl_r) ? rl_r : ang_r;
  assign a_abs  = a_neg[15] ? (~a_neg + 16'd1) : a_neg;
  assign t_sel  = tgt_r[cmd.idx];

  // operand selection for the shared multiplier and divisor
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    div_sel  = '0;
    zdiv_sel = 1'b0;
    mode_sel = MODE_POS;
    if (cmd.ang_prep) begin
      if (!ang_r[15]) begin
        mul_a    = {1'b0, ll_r - a_pos};
        mul_b    = cp_r;
        div_sel  = {1'b0, ll_r};
        zdiv_sel = (ll_r == '0);
        mode_sel = MODE_POS;
      end else begin
        mul_a    = a_abs;
        mul_b    = c_comp;
        div_sel  = rl_abs;
        zdiv_sel = (rl_r == '0);
        mode_sel = MODE_NEG;
      end
    end else begin
      if (t_sel <= cp_r) begin
        mul_a    = {1'b0, ll_r};
        mul_b    = t_sel;
        div_sel  = {8'd0, cp_r};
        zdiv_sel = (cp_r == '0);
        mode_sel = MODE_LO;
      end else begin
        mul_a    = rl_abs;
        mul_b    = t_sel - cp_r;
        div_sel  = {8'd0, c_comp};
        zdiv_sel = 1'b0;
        mode_sel = MODE_HI;
      end
    end
  end

  assign prod = NUM_W'(mul_a) * NUM_W'(mul_b);

  // restoring division, one quotient bit per step
  assign shl = {rem_r, quo_r[NUM_W-1]};
  assign ge  = (shl >= {1'b0, div_r});

  // finishing the quotient
  assign qv = zdiv_r ? '0 : quo_r;

  always_comb begin
    t_raw = qv[7:0];
    case (mode_r)
      MODE_POS: t_raw = zdiv_r ? cp_r : qv[7:0];
      MODE_NEG: t_raw = qv[7:0] + cp_r;
      default:  t_raw = qv[7:0];
    endcase
    if (t_raw < TGT_MIN) begin
      t_new = TGT_MIN;
    end else if (t_raw > TGT_MAX) begin
      t_new = TGT_MAX;
    end else begin
      t_new = t_raw;
    end
  end

  always_comb begin
    if (mode_r == MODE_LO) begin
      g_ang = {1'b0, ll_r} - qv[15:0];
    end else if (rl_r[15]) begin
      g_ang = ~qv[15:0] + 16'd1;
    end else begin
      g_ang = qv[15:0];
    end
  end

  assign pw_prod = 15'(act_r[cmd.idx]) * PW_MUL;
  assign pw      = 12'(pw_prod >> PW_SHIFT) + PW_OFS;

  // slew step of every channel
  always_comb begin
    logic [8:0] a_up;
    logic [8:0] t_up;
    for (int i = 0; i < NUM_CH; i++) begin
      a_up = {1'b0, act_r[i]} + {1'b0, ms_r};
      t_up = {1'b0, tgt_r[i]} + {1'b0, ms_r};
      if ({1'b0, act_r[i]} > t_up) begin
        act_nxt[i] = act_r[i] - ms_r;
      end else if (a_up < {1'b0, tgt_r[i]}) begin
        act_nxt[i] = a_up[7:0];
      end else begin
        act_nxt[i] = tgt_r[i];
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r <= MAX_STEP_RST;
      cp_r <= CENTER_RST;
      ll_r <= LEFT_RST;
      rl_r <= RIGHT_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAX_STEP: ms_r <= cfg_data[7:0];
        REG_CENTER:   cp_r <= cfg_data[7:0];
        REG_LEFT:     ll_r <= cfg_data[14:0];
        REG_RIGHT:    rl_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        act_r[i] <= POS_RESET;
        tgt_r[i] <= POS_RESET;
        en_r[i]  <= 1'b1;
      end
    end else begin
      if (cmd.slew) begin
        for (int i = 0; i < NUM_CH; i++) begin
          act_r[i] <= act_nxt[i];
        end
      end
      if (cmd.set_raw && ch_ok) begin
        tgt_r[ch_r] <= raw_r;
      end
      if (cmd.ang_wr && ch_ok) begin
        tgt_r[ch_r] <= t_new;
      end
      if (cmd.set_en && ch_ok) begin
        en_r[ch_r] <= flag_r;
      end
    end
  end

  // captured item, control part
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= CMD_TICK;
    end else if (cmd.cap) begin
      cmd_r <= cmd_code_t'(in_command);
    end
  end

  // captured item, payload part
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      ch_r   <= in_channel;
      raw_r  <= in_raw_target;
      ang_r  <= in_angle_in;
      flag_r <= in_enable_flag;
    end
  end

  // multiplier result, divisor and divider iteration
  always_ff @(posedge clk) begin
    if (cmd.ang_prep || cmd.t2a_prep) begin
      quo_r  <= prod;
      rem_r  <= '0;
      div_r  <= div_sel;
      zdiv_r <= zdiv_sel;
      mode_r <= mode_sel;
    end else if (cmd.div_step) begin
      rem_r <= ge ? DIV_W'(shl - {1'b0, div_r}) : shl[DIV_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch_r   <= cmd.idx;
      out_pw_r   <= pw;
      out_pos_r  <= act_r[cmd.idx];
      out_goal_r <= tgt_r[cmd.idx];
      out_ang_r  <= g_ang;
      out_act_r  <= en_r[cmd.idx];
      out_last_r <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_ch_r;
  assign out_pulse_width = out_pw_r;
  assign out_position    = out_pos_r;
  assign out_goal        = out_goal_r;
  assign out_goal_angle  = out_ang_r;
  assign out_active      = out_act_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  // at or below centre the quotient never exceeds the left limit
  a_lo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && mode_r == MODE_LO && !zdiv_r) |-> (quo_r <= NUM_W'(ll_r)))
    else $error("target-to-angle quotient above left limit");

  // above centre the quotient never exceeds the right limit magnitude
  a_hi_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && mode_r == MODE_HI) |-> (quo_r <= NUM_W'(rl_abs)))
    else $error("target-to-angle quotient above right limit");

  // on channel 0, a tick lands on the target or moves exactly max_step
  a_slew: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.slew |=> (act_r[0] == tgt_r[0]) ||
                 (act_r[0] == $past(act_r[0]) - ms_r) ||
                 (act_r[0] == $past(act_r[0]) + ms_r))
    else $error("slew step out of range on channel 0");
`endif

endmodule
